// ===== design/mrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared types and constants of the MADT record parser.
// ----------------------------------------------------------------------------
package mrp_pkg;

  localparam int MaxCpus = 16;

  localparam logic [7:0]  TypeLapic        = 8'd0;
  localparam logic [7:0]  TypeIoapic       = 8'd1;
  localparam logic [7:0]  ApicLapicEnabled = 8'd1;
  localparam logic [31:0] HdrLen           = 32'd44;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLapicAddr  = 1'b0,
    CfgIoapicAddr = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PhIdle,
    PhHeader,
    PhRecords,
    PhHalt
  } phase_e;

  typedef enum logic [1:0] {
    KindCpu      = 2'd0,
    KindIoapic   = 2'd1,
    KindFinished = 2'd2,
    KindError    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ErrShortTable  = 3'd0,
    ErrBadLapic    = 3'd1,
    ErrBadIoapic   = 3'd2,
    ErrSecondIoapic = 3'd3,
    ErrNoCpu       = 3'd4,
    ErrTooManyCpus = 3'd5
  } err_e;

  typedef struct packed {
    logic [7:0] table_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    err_e       error_code;
    logic [3:0] cpu_index;
    logic [7:0] apic_id;
    logic [7:0] ioapic_id;
    logic [4:0] cpu_count;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [31:0] lapic_address;
    logic [31:0] ioapic_address;
  } cfg_t;

  // results caused by one byte; r1 only when second is set
  typedef struct packed {
    logic    second;
    result_t r0;
    result_t r1;
  } pair_t;

endpackage

// ===== design/madt_record_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_record_parser
// Streams an MADT byte by byte and reports cpus, the IO controller, the
// final cpu count or an error.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in      | in  | in_valid / stall   | in_item_t  (table_byte, start_req)
//  out     | out | out_valid / stall  | result_t   (one result per request)
//  cfg     | in  | cfg_valid / ready  | cfg_index, cfg_data (32 bit)
//
// One byte per cycle while in_stall is low; the parser state is updated with each byte.
// A byte may cause up to two results; the output side sends one per cycle while out_stall is low.
// A four-entry queue of result pairs parts parser and output side; in_stall
// is high only while it is full.
// Reset clears parse state and loads default controller addresses.
// ----------------------------------------------------------------------------
module madt_record_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mrp_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mrp_pkg::result_t                out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mrp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import mrp_pkg::*;

  cfg_t  cfg_q;
  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  pair_t q_in;
  pair_t q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lapic_address  <= 32'hFEE0_0000;
      cfg_q.ioapic_address <= 32'hFEC0_0000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgLapicAddr:  cfg_q.lapic_address  <= cfg_data_i;
        CfgIoapicAddr: cfg_q.ioapic_address <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mrp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .pair_o     (q_in)
  );

  mrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .pair_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  mrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_of_run) |=> out_valid_o)
    else $error("second result of a byte not sent next");

  a_finish_has_cpus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KindFinished) |-> out_data_o.cpu_count != 5'd0)
    else $error("finish reported with no cpu");

  a_err_code_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind != KindError) |-> out_data_o.error_code == ErrShortTable)
    else $error("error code set on a non-error result");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> !q_empty)
    else $error("queue lost a pushed pair");

endmodule

// ===== design/mrp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrp_front
// Byte parser: walks header and records, builds the results of each byte.
// ----------------------------------------------------------------------------
module mrp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  mrp_pkg::in_item_t in_data_i,
  output logic              in_stall_o,
  input  mrp_pkg::cfg_t     cfg_i,
  input  logic              q_full_i,
  output logic              push_o,
  output mrp_pkg::pair_t    pair_o
);
  import mrp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [5:0]  hoff_q, hoff_d;
  logic [31:0] trem_q, trem_d;
  logic [7:0]  rtype_q, rtype_d;
  logic [7:0]  rlen_q, rlen_d;
  logic [7:0]  roff_q, roff_d;
  logic [7:0]  cid_q, cid_d;
  logic        en_q, en_d;
  logic [31:0] caddr_q, caddr_d;
  logic [4:0]  cpus_q, cpus_d;
  logic        ioseen_q, ioseen_d;

  logic        accept;
  logic [1:0]  n_res;
  result_t     res [2];
  logic [7:0]  b;
  logic [5:0]  off;
  logic [7:0]  ro;
  logic        go_on;

  function automatic result_t mk_res(kind_e k, err_e e, logic [3:0] idx,
                                     logic [7:0] apic, logic [7:0] ioid,
                                     logic [4:0] cnt);
    result_t r;
    r.kind        = k;
    r.error_code  = e;
    r.cpu_index   = idx;
    r.apic_id     = apic;
    r.ioapic_id   = ioid;
    r.cpu_count   = cnt;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_fail(err_e e);
    return mk_res(KindError, e, 4'd0, 8'd0, 8'd0, 5'd0);
  endfunction

  function automatic result_t mk_finish(logic [4:0] cnt);
    if (cnt == 5'd0) begin
      return mk_fail(ErrNoCpu);
    end
    return mk_res(KindFinished, ErrShortTable, 4'd0, 8'd0, 8'd0, cnt);
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign b          = in_data_i.table_byte;

  always_comb begin
    phase_d  = phase_q;
    hoff_d   = hoff_q;
    trem_d   = trem_q;
    rtype_d  = rtype_q;
    rlen_d   = rlen_q;
    roff_d   = roff_q;
    cid_d    = cid_q;
    en_d     = en_q;
    caddr_d  = caddr_q;
    cpus_d   = cpus_q;
    ioseen_d = ioseen_q;
    n_res    = 2'd0;
    res[0]   = mk_fail(ErrShortTable);
    res[1]   = mk_fail(ErrShortTable);
    off      = 6'd0;
    ro       = 8'd0;
    go_on    = 1'b0;

    if (accept) begin
      if (in_data_i.start_req) begin
        phase_d  = PhHeader;
        hoff_d   = 6'd0;
        trem_d   = 32'd0;
        rtype_d  = 8'd0;
        rlen_d   = 8'd0;
        roff_d   = 8'd0;
        cid_d    = 8'd0;
        en_d     = 1'b0;
        caddr_d  = 32'd0;
        cpus_d   = 5'd0;
        ioseen_d = 1'b0;
      end

      unique case (phase_d)
        PhHeader: begin
          off = hoff_d;
          if (off >= 6'd4 && off <= 6'd7) begin
            trem_d[{off[1:0], 3'b000} +: 8] = b;
          end
          if (off >= 6'd36 && off <= 6'd39) begin
            caddr_d[{off[1:0], 3'b000} +: 8] = b;
          end
          if (off == 6'd7 && trem_d < HdrLen) begin
            res[n_res[0]] = mk_fail(ErrShortTable);
            n_res         = n_res + 2'd1;
            phase_d       = PhHalt;
          end else if (off == 6'd39 && caddr_d != cfg_i.lapic_address) begin
            res[n_res[0]] = mk_fail(ErrBadLapic);
            n_res         = n_res + 2'd1;
            phase_d       = PhHalt;
          end else if (off >= 6'd43) begin
            trem_d  = trem_d - HdrLen;
            caddr_d = 32'd0;
            roff_d  = 8'd0;
            if (trem_d == 32'd0) begin
              res[n_res[0]] = mk_finish(cpus_d);
              n_res         = n_res + 2'd1;
              phase_d       = PhHalt;
            end else begin
              phase_d = PhRecords;
            end
          end else begin
            hoff_d = off + 6'd1;
          end
        end

        PhRecords: begin
          ro    = roff_d;
          go_on = 1'b1;
          if (ro == 8'd0) begin
            go_on = 1'b0;
            if (trem_d < 32'd2) begin
              trem_d        = 32'd0;
              res[n_res[0]] = mk_finish(cpus_d);
              n_res         = n_res + 2'd1;
              phase_d       = PhHalt;
            end else begin
              rtype_d = b;
              cid_d   = 8'd0;
              en_d    = 1'b0;
              caddr_d = 32'd0;
              trem_d  = trem_d - 32'd1;
              roff_d  = 8'd1;
            end
          end else if (ro == 8'd1) begin
            if (b < 8'd2 || ({1'b0, trem_d} + 33'd1) < {25'd0, b}) begin
              go_on         = 1'b0;
              res[n_res[0]] = mk_finish(cpus_d);
              n_res         = n_res + 2'd1;
              phase_d       = PhHalt;
            end else begin
              rlen_d = b;
            end
          end else if (rtype_d == TypeLapic) begin
            if (ro == 8'd3) begin
              cid_d = b;
            end else if (ro == 8'd4) begin
              en_d = |(b & ApicLapicEnabled);
            end
          end else if (rtype_d == TypeIoapic) begin
            if (ro == 8'd2) begin
              cid_d = b;
            end else if (ro >= 8'd4 && ro <= 8'd7) begin
              caddr_d[{ro[1:0], 3'b000} +: 8] = b;
            end
          end

          if (go_on) begin
            if (trem_d != 32'd0) begin
              trem_d = trem_d - 32'd1;
            end
            if (({1'b0, ro} + 9'd1) >= {1'b0, rlen_d}) begin
              roff_d = 8'd0;
              if (rtype_d == TypeLapic && rlen_d >= 8'd8) begin
                if (en_d) begin
                  if (cpus_d >= 5'(MaxCpus)) begin
                    res[n_res[0]] = mk_fail(ErrTooManyCpus);
                    n_res         = n_res + 2'd1;
                    phase_d       = PhHalt;
                  end else begin
                    res[n_res[0]] = mk_res(KindCpu, ErrShortTable, cpus_d[3:0], cid_d,
                                           8'd0, 5'd0);
                    n_res         = n_res + 2'd1;
                    cpus_d        = cpus_d + 5'd1;
                  end
                end
              end else if (rtype_d == TypeIoapic && rlen_d >= 8'd12) begin
                if (caddr_d != cfg_i.ioapic_address) begin
                  res[n_res[0]] = mk_fail(ErrBadIoapic);
                  n_res         = n_res + 2'd1;
                  phase_d       = PhHalt;
                end else if (ioseen_d) begin
                  res[n_res[0]] = mk_fail(ErrSecondIoapic);
                  n_res         = n_res + 2'd1;
                  phase_d       = PhHalt;
                end else begin
                  ioseen_d      = 1'b1;
                  res[n_res[0]] = mk_res(KindIoapic, ErrShortTable, 4'd0, 8'd0, cid_d,
                                         5'd0);
                  n_res         = n_res + 2'd1;
                end
              end
              if (phase_d == PhRecords && trem_d == 32'd0) begin
                res[n_res[0]] = mk_finish(cpus_d);
                n_res         = n_res + 2'd1;
                phase_d       = PhHalt;
              end
            end else begin
              roff_d = ro + 8'd1;
            end
          end
        end

        PhIdle, PhHalt: begin
        end

        default: begin
        end
      endcase
    end

    res[0].last_of_run = (n_res == 2'd1);
    res[1].last_of_run = 1'b1;
  end

  assign push_o      = accept && (n_res != 2'd0);
  assign pair_o.second = (n_res == 2'd2);
  assign pair_o.r0   = res[0];
  assign pair_o.r1   = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      hoff_q   <= 6'd0;
      trem_q   <= 32'd0;
      rtype_q  <= 8'd0;
      rlen_q   <= 8'd0;
      roff_q   <= 8'd0;
      cid_q    <= 8'd0;
      en_q     <= 1'b0;
      caddr_q  <= 32'd0;
      cpus_q   <= 5'd0;
      ioseen_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      hoff_q   <= hoff_d;
      trem_q   <= trem_d;
      rtype_q  <= rtype_d;
      rlen_q   <= rlen_d;
      roff_q   <= roff_d;
      cid_q    <= cid_d;
      en_q     <= en_d;
      caddr_q  <= caddr_d;
      cpus_q   <= cpus_d;
      ioseen_q <= ioseen_d;
    end
  end

endmodule

// ===== design/mrp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrp_queue
// Short FIFO of result pairs between parser and output side.
// ----------------------------------------------------------------------------
module mrp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mrp_pkg::pair_t pair_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mrp_pkg::pair_t head_o
);
  import mrp_pkg::*;

  pair_t            mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + QPtrW'(1);
      cnt_d  = cnt_d + QCntW'(1);
    end
    if (pop_i) begin
      rptr_d = rptr_q + QPtrW'(1);
      cnt_d  = cnt_d - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= pair_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== design/mrp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrp_back
// Output side: unpacks result pairs into single requests on the output.
// ----------------------------------------------------------------------------
module mrp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  mrp_pkg::pair_t   head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mrp_pkg::result_t out_data_o
);
  import mrp_pkg::*;

  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    pend_q, pend_d;
  result_t sec_q, sec_d;
  logic    load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pend_d      = pend_q;
    sec_d       = sec_q;
    pop_o       = 1'b0;
    if (load) begin
      if (pend_q) begin
        out_d       = sec_q;
        out_valid_d = 1'b1;
        pend_d      = 1'b0;
      end else if (!empty_i) begin
        pop_o       = 1'b1;
        out_d       = head_i.r0;
        out_valid_d = 1'b1;
        pend_d      = head_i.second;
        sec_d       = head_i.r1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sec_q <= sec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sim/madt_record_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_record_parser_tb
// Sends whole and damaged MADT images byte by byte. A behavioural copy of the
// parser predicts each cpu, IO controller, finish and error report. Every
// report the block hands out is checked field by field against that
// prediction, under random input gaps and random output stalls.
// ----------------------------------------------------------------------------
module madt_record_parser_tb;
  import mrp_pkg::*;

  typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  // the error field reads zero unless the kind is an error
  localparam err_e NoErr = ErrShortTable;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  result_t             out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgLapicAddr;
  logic [31:0]         cfg_data_i  = '0;

  madt_record_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // parser copy
  logic [31:0] lapic_cfg  = 32'hFEE0_0000;
  logic [31:0] ioapic_cfg = 32'hFEC0_0000;
  phase_e      ph         = PhIdle;
  logic [5:0]  hdr_off    = '0;
  logic [31:0] remaining  = '0;
  logic [7:0]  rec_type   = '0;
  logic [7:0]  rec_len    = '0;
  logic [7:0]  rec_off    = '0;
  logic [7:0]  cap_id     = '0;
  logic        en_bit     = 1'b0;
  logic [31:0] cap_addr   = '0;
  logic [4:0]  ncpus      = '0;
  logic        io_seen    = 1'b0;

  result_t     step_results[$];
  result_t     expected_reports[$];
  int          live_bytes        = 0;
  int          fail_count        = 0;
  int          burst_left        = 0;
  logic [7:0]  tbl[$];
  result_t     dut_report;
  result_t     next_expected;

  function automatic void emit(kind_e k, err_e e, logic [3:0] idx, logic [7:0] apic,
                               logic [7:0] ioid, logic [4:0] cnt);
    result_t r;
    r = '{kind: k, error_code: e, cpu_index: idx, apic_id: apic, ioapic_id: ioid,
          cpu_count: cnt, last_of_run: 1'b0};
    step_results.push_back(r);
  endfunction

  function automatic void raise_error(err_e e);
    emit(KindError, e, '0, '0, '0, '0);
    ph = PhHalt;
  endfunction

  function automatic void close_table();
    ph = PhHalt;
    if (ncpus == 0) raise_error(ErrNoCpu);
    else emit(KindFinished, NoErr, '0, '0, '0, ncpus);
  endfunction

  function automatic void close_record();
    if (rec_type == TypeLapic && rec_len >= 8) begin
      if (en_bit) begin
        if (ncpus >= MaxCpus) begin
          raise_error(ErrTooManyCpus);
        end else begin
          emit(KindCpu, NoErr, ncpus[3:0], cap_id, '0, '0);
          ncpus++;
        end
      end
    end else if (rec_type == TypeIoapic && rec_len >= 12) begin
      if (cap_addr != ioapic_cfg) raise_error(ErrBadIoapic);
      else if (io_seen) raise_error(ErrSecondIoapic);
      else begin
        io_seen = 1'b1;
        emit(KindIoapic, NoErr, '0, '0, cap_id, '0);
      end
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic s);
    int unsigned off;
    int unsigned ro;
    bit          go_on;
    step_results.delete();
    if (s || ph == PhHeader || ph == PhRecords) live_bytes++;
    if (s) begin
      hdr_off = '0; remaining = '0; rec_type = '0; rec_len = '0; rec_off = '0;
      cap_id = '0; en_bit = 1'b0; cap_addr = '0; ncpus = '0; io_seen = 1'b0;
      ph = PhHeader;
    end
    if (ph == PhHeader) begin
      off = hdr_off;
      if (off >= 4 && off <= 7) remaining |= 32'(b) << (8 * (off - 4));
      if (off >= 36 && off <= 39) cap_addr |= 32'(b) << (8 * (off - 36));
      if (off == 7 && remaining < HdrLen) begin
        raise_error(ErrShortTable);
      end else if (off == 39 && cap_addr != lapic_cfg) begin
        raise_error(ErrBadLapic);
      end else if (off >= HdrLen - 1) begin
        remaining -= HdrLen;
        cap_addr = '0;
        rec_off = '0;
        if (remaining == 0) close_table();
        else ph = PhRecords;
      end else begin
        hdr_off = 6'(off + 1);
      end
    end else if (ph == PhRecords) begin
      ro = rec_off;
      go_on = 1'b1;
      if (ro == 0) begin
        if (remaining < 2) begin
          remaining = '0;
          close_table();
        end else begin
          rec_type = b; cap_id = '0; en_bit = 1'b0; cap_addr = '0;
          remaining--;
          rec_off = 8'd1;
        end
        go_on = 1'b0;
      end else if (ro == 1) begin
        if (b < 2 || {1'b0, remaining} + 33'd1 < 33'(b)) begin
          close_table();
          go_on = 1'b0;
        end else begin
          rec_len = b;
        end
      end else if (rec_type == TypeLapic) begin
        if (ro == 3) cap_id = b;
        else if (ro == 4) en_bit = |(b & ApicLapicEnabled);
      end else if (rec_type == TypeIoapic) begin
        if (ro == 2) cap_id = b;
        else if (ro >= 4 && ro <= 7) cap_addr |= 32'(b) << (8 * (ro - 4));
      end
      if (go_on) begin
        if (remaining > 0) remaining--;
        if (ro + 1 >= rec_len) begin
          rec_off = '0;
          close_record();
          if (ph == PhRecords && remaining == 0) close_table();
        end else begin
          rec_off = 8'(ro + 1);
        end
      end
    end
    if (step_results.size() != 0) step_results[step_results.size() - 1].last_of_run = 1'b1;
    foreach (step_results[i]) expected_reports.push_back(step_results[i]);
  endfunction

  // checking
  task automatic report(string msg);
    fail_count++;
    if (fail_count <= 40) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  // sampled mid-cycle: a request is taken at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      dut_report = out_data_o;
      if (expected_reports.size() == 0) begin
        report($sformatf("unexpected report, kind %0d", dut_report.kind));
      end else begin
        next_expected = expected_reports.pop_front();
        check_field("kind", dut_report.kind, next_expected.kind);
        check_field("error_code", dut_report.error_code, next_expected.error_code);
        check_field("cpu_index", dut_report.cpu_index, next_expected.cpu_index);
        check_field("apic_id", dut_report.apic_id, next_expected.apic_id);
        check_field("ioapic_id", dut_report.ioapic_id, next_expected.ioapic_id);
        check_field("cpu_count", dut_report.cpu_count, next_expected.cpu_count);
        check_field("last_of_run", dut_report.last_of_run, next_expected.last_of_run);
      end
    end
  end

  // output back-pressure
  stall_mode_e stall_mode = StallNone;
  int          stall_left = 0;
  int unsigned cycle_cnt  = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= (cycle_cnt % 5) < 2;
    endcase
  end

  // stimulus
  task automatic send_byte(logic [7:0] b, logic s);
    int unsigned gap;
    logic        stalled;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{table_byte: b, start_req: s};
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    burst_left--;
    parse_byte(b, s);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_config(logic [31:0] lapic, logic [31:0] ioapic);
    cfg_reg_e    idx;
    logic [31:0] val;
    logic        ready;
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 2; i++) begin
      idx = (i == 0) ? CfgLapicAddr : CfgIoapicAddr;
      val = (idx == CfgLapicAddr) ? lapic : ioapic;
      cfg_index_i <= idx;
      cfg_data_i  <= val;
      do begin
        @(negedge clk_i);
        ready = cfg_ready_o;
        @(posedge clk_i);
      end while (!ready);
      if (idx == CfgLapicAddr) lapic_cfg = val;
      else ioapic_cfg = val;
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void put_le32(logic [31:0] v);
    for (int i = 0; i < 4; i++) tbl.push_back(v[8*i +: 8]);
  endfunction

  // length bytes are patched in when the table is sent
  function automatic void new_header(logic [31:0] lapic_addr);
    tbl.delete();
    for (int i = 0; i < 36; i++) tbl.push_back(8'($urandom));
    put_le32(lapic_addr);
    put_le32($urandom);
  endfunction

  // word: flags byte of a local record, address of an IO record
  function automatic void add_record(logic [7:0] rtype, logic [7:0] len, logic [7:0] id,
                                     logic [31:0] word);
    int unsigned base;
    base = tbl.size();
    tbl.push_back(rtype);
    tbl.push_back(len);
    for (int i = 2; i < len; i++) tbl.push_back(8'($urandom));
    if (rtype == TypeLapic) begin
      if (len > 3) tbl[base + 3] = id;
      if (len > 4) tbl[base + 4] = word[7:0];
    end else if (rtype == TypeIoapic) begin
      if (len > 2) tbl[base + 2] = id;
      for (int i = 4; i < 8 && i < len; i++) tbl[base + i] = word[8*(i-4) +: 8];
    end
  endfunction

  task automatic send_table(logic [31:0] len_field, int unsigned count);
    for (int i = 0; i < 4; i++) if (4 + i < tbl.size()) tbl[4 + i] = len_field[8*i +: 8];
    for (int i = 0; i < count && i < tbl.size(); i++) send_byte(tbl[i], i == 0);
  endtask

  task automatic test_ignored_bytes();
    repeat (3) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic test_header_errors();
    new_header(lapic_cfg);
    send_table(32'd43, 12);
    new_header(lapic_cfg);
    send_table(32'd0, 8);
    new_header(~lapic_cfg);
    send_table(32'd44, 44);
    new_header(lapic_cfg);
    send_table(32'd44, 44);
  endtask

  task automatic test_record_kinds();
    new_header(lapic_cfg);
    add_record(TypeLapic, 8'd8, 8'hFF, 32'h01);
    add_record(TypeLapic, 8'd8, 8'h05, 32'hFE);
    add_record(TypeLapic, 8'd7, 8'h06, 32'h01);
    add_record(TypeIoapic, 8'd12, 8'hA5, ioapic_cfg);
    add_record(TypeIoapic, 8'd11, 8'h11, ioapic_cfg);
    add_record(8'd2, 8'd10, 8'h00, $urandom);
    add_record(8'hFF, 8'd2, 8'h00, $urandom);
    add_record(TypeLapic, 8'd40, 8'h00, 32'h01);
    add_record(TypeLapic, 8'd8, 8'h80, 32'hFF);
    send_table(tbl.size(), tbl.size());
  endtask

  task automatic test_walk_endings();
    // one stray byte left at a record start
    new_header(lapic_cfg);
    add_record(TypeLapic, 8'd8, 8'h21, 32'h01);
    tbl.push_back(8'($urandom));
    send_table(tbl.size(), tbl.size());
    // record length of 0 and 1, trailing bytes ignored
    for (int l = 0; l < 2; l++) begin
      new_header(lapic_cfg);
      add_record(TypeLapic, 8'd8, 8'h22, 32'h01);
      add_record(TypeLapic, 8'(l), 8'h00, 32'h0);
      repeat (5) tbl.push_back(8'($urandom));
      send_table(tbl.size(), tbl.size());
    end
    // record longer than the table
    new_header(lapic_cfg);
    add_record(TypeLapic, 8'd8, 8'h23, 32'h01);
    tbl.push_back(TypeIoapic);
    tbl.push_back(8'd200);
    repeat (10) tbl.push_back(8'($urandom));
    send_table(tbl.size(), tbl.size());
    // IO controller only: its report then no-cpu on the same byte
    new_header(lapic_cfg);
    add_record(TypeIoapic, 8'd12, 8'h00, ioapic_cfg);
    send_table(tbl.size(), tbl.size());
  endtask

  task automatic test_ioapic_errors();
    new_header(lapic_cfg);
    add_record(TypeLapic, 8'd8, 8'h01, 32'h01);
    add_record(TypeIoapic, 8'd12, 8'h02, ~ioapic_cfg);
    add_record(TypeLapic, 8'd8, 8'h03, 32'h01);
    send_table(tbl.size(), tbl.size());
    new_header(lapic_cfg);
    add_record(TypeIoapic, 8'd12, 8'h04, ioapic_cfg);
    add_record(TypeLapic, 8'd8, 8'h05, 32'h01);
    add_record(TypeIoapic, 8'd16, 8'h06, ioapic_cfg);
    add_record(TypeLapic, 8'd8, 8'h07, 32'h01);
    send_table(tbl.size(), tbl.size());
  endtask

  // every cpu index in turn, then one cpu too many
  task automatic test_cpu_limit();
    new_header(lapic_cfg);
    for (int i = 0; i < MaxCpus + 1; i++) add_record(TypeLapic, 8'd8, 8'(i * 17), 32'h01);
    send_table(tbl.size(), tbl.size());
  endtask

  function automatic void add_random_record();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 12)
      add_record(TypeLapic, ($urandom_range(0, 5) == 0) ? 8'($urandom_range(2, 12)) : 8'd8,
                 8'($urandom), {24'($urandom), 7'($urandom), ($urandom_range(0, 4) != 0)});
    else if (pick < 15)
      add_record(TypeIoapic, ($urandom_range(0, 5) == 0) ? 8'($urandom_range(2, 16)) : 8'd12,
                 8'($urandom), ($urandom_range(0, 5) == 0) ? $urandom : ioapic_cfg);
    else if (pick < 19)
      add_record(8'($urandom_range(2, 255)), 8'($urandom_range(2, 24)), 8'($urandom), $urandom);
    else
      add_record(8'($urandom), 8'($urandom_range(0, 1)), 8'($urandom), $urandom);
  endfunction

  task automatic send_random_table();
    logic [31:0] len_field;
    int unsigned count;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end else begin
      new_header(($urandom_range(0, 15) == 0) ? $urandom : lapic_cfg);
      repeat ($urandom_range(0, 6)) add_random_record();
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 3)) tbl.push_back(8'($urandom));
        1: ;
        2: ;
        3: ;
        4: tbl[$urandom_range(0, tbl.size() - 1)] = 8'($urandom);
        default: ;
      endcase
      len_field = tbl.size();
      count     = tbl.size();
      case ($urandom_range(0, 9))
        1: len_field = $urandom_range(0, tbl.size());
        2: count = $urandom_range(1, tbl.size());
        3: len_field = $urandom;
        default: ;
      endcase
      send_table(len_field, count);
    end
  endtask

  task automatic test_random_tables();
    int live_goal;
    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0:       write_config(32'h0000_0000, 32'h0000_0000);
        1:       write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: write_config($urandom, $urandom);
      endcase
      live_goal = live_bytes + 40;
      while (live_bytes < live_goal) send_random_table();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ignored_bytes();
    test_header_errors();
    test_record_kinds();
    test_walk_endings();
    test_ioapic_errors();
    test_cpu_limit();
    test_random_tables();
    drain();
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
design/mrp_pkg.sv
design/mrp_front.sv
design/mrp_queue.sv
design/mrp_back.sv
design/madt_record_parser.sv
sim/madt_record_parser_tb.sv
